>>> rtl/mmf_pkg.sv
package mmf_pkg;

  localparam int WINDOW   = 15;
  localparam int SAMPLE_W = 16;
  localparam int AGE_W    = (WINDOW > 2) ? $clog2(WINDOW) : 1;
  localparam int CNT_W    = $clog2(WINDOW + 1);
  localparam int MID      = WINDOW / 2;

  localparam logic [AGE_W-1:0] AGE_LAST = AGE_W'(WINDOW - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(WINDOW);

  // one slot of the sorted row
  typedef struct packed {
    logic                       vld;
    logic signed [SAMPLE_W-1:0] value;
    logic [AGE_W-1:0]           age;
  } slot_t;

  // flags a cell hands to its neighbors
  typedef struct packed {
    logic lt_new;    // slot sorts below the new sample
    logic at_del;    // slot at or above the one leaving
    logic lt_shift;  // lt_new after the leaving slot is closed up
  } cell_flags_t;

  // per-item data broadcast along the row
  typedef struct packed {
    logic                       en;
    logic                       clear;
    logic                       del_en;
    logic signed [SAMPLE_W-1:0] del_value;
    logic signed [SAMPLE_W-1:0] sample;
  } row_ctrl_t;

endpackage

>>> rtl/mmf_cell.sv
module mmf_cell (
  input  logic                clk,
  input  logic                rst,
  input  mmf_pkg::row_ctrl_t  ctrl,
  input  mmf_pkg::slot_t      dn_slot,
  input  mmf_pkg::slot_t      up_slot,
  input  mmf_pkg::cell_flags_t dn_flags,
  input  logic                up_lt_new,
  output mmf_pkg::slot_t      slot_eff,
  output mmf_pkg::cell_flags_t flags,
  output logic                del_here,
  output mmf_pkg::slot_t      slot_next
);

  mmf_pkg::slot_t slot;
  mmf_pkg::slot_t src_cur;
  mmf_pkg::slot_t src_dn;

  always_comb begin
    slot_eff     = slot;
    slot_eff.vld = slot.vld && !ctrl.clear;

    del_here = slot_eff.vld && ctrl.del_en && (slot.age == mmf_pkg::AGE_LAST);

    flags.lt_new   = slot_eff.vld && (slot.value < ctrl.sample);
    flags.at_del   = ctrl.del_en && slot_eff.vld &&
                     ((slot.value > ctrl.del_value) || del_here);
    flags.lt_shift = flags.at_del ? up_lt_new : flags.lt_new;

    src_cur = flags.at_del ? up_slot : slot_eff;
    src_dn  = dn_flags.at_del ? slot_eff : dn_slot;

    if (flags.lt_shift) begin
      slot_next     = src_cur;
      slot_next.age = src_cur.age + 1'b1;
    end else if (dn_flags.lt_shift) begin
      slot_next.vld   = 1'b1;
      slot_next.value = ctrl.sample;
      slot_next.age   = '0;
    end else begin
      slot_next     = src_dn;
      slot_next.age = src_dn.age + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot.vld <= 1'b0;
    end else if (ctrl.en) begin
      slot.vld <= slot_next.vld;
    end
    if (ctrl.en) begin
      slot.value <= slot_next.value;
      slot.age   <= slot_next.age;
    end
  end

endmodule

>>> rtl/moving_median_filter.sv
// Running median over the last WINDOW samples of a record (mmf_pkg::WINDOW).
// Takes one item per clock while s_tready is high; the median of an item is
// loaded into the output register as the item is accepted. Samples live in
// a row of WINDOW cells kept sorted by value, each tagged with its age. Each
// item slides into place; once the row is full the oldest sample is closed
// up, so the middle cell then holds the median. A set start flag begins a
// new record with the item itself. No result until the record holds WINDOW
// samples. s_tready drops only while a result waits on m_tready.
module moving_median_filter (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [15:0] sample
  input  logic [0:0]  s_tuser,   // [0] start_req
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata    // [15:0] median
);

  localparam int N = mmf_pkg::WINDOW;

  mmf_pkg::row_ctrl_t   ctrl;
  mmf_pkg::slot_t       slot_eff  [N];
  mmf_pkg::slot_t       slot_next [N];
  mmf_pkg::slot_t       dn_slot   [N];
  mmf_pkg::slot_t       up_slot   [N];
  mmf_pkg::cell_flags_t flags     [N];
  mmf_pkg::cell_flags_t dn_flags  [N];
  logic                 up_lt_new [N];
  logic [N-1:0]         del_here;

  logic [mmf_pkg::CNT_W-1:0] cnt;
  logic [mmf_pkg::CNT_W-1:0] cnt_eff;
  logic [mmf_pkg::CNT_W-1:0] cnt_next;
  logic signed [mmf_pkg::SAMPLE_W-1:0] del_value;
  logic accept;

  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;

  always_comb begin
    cnt_eff   = s_tuser[0] ? '0 : cnt;
    cnt_next  = (cnt_eff == mmf_pkg::CNT_FULL) ? cnt_eff : cnt_eff + 1'b1;
    del_value = '0;
    for (int i = 0; i < N; i++) begin
      if (del_here[i]) begin
        del_value = del_value | slot_eff[i].value;
      end
    end
    ctrl.en        = accept;
    ctrl.clear     = s_tuser[0];
    ctrl.del_en    = (cnt_eff == mmf_pkg::CNT_FULL);
    ctrl.del_value = del_value;
    ctrl.sample    = s_tdata;
  end

  genvar g;
  generate
    for (g = 0; g < N; g++) begin : g_row
      if (g == 0) begin : g_first
        always_comb begin
          dn_slot[g]           = '0;
          dn_flags[g]          = '0;
          dn_flags[g].lt_shift = 1'b1;
        end
      end else begin : g_mid
        always_comb begin
          dn_slot[g]  = slot_eff[g-1];
          dn_flags[g] = flags[g-1];
        end
      end
      if (g == N - 1) begin : g_last
        always_comb begin
          up_slot[g]   = '0;
          up_lt_new[g] = 1'b0;
        end
      end else begin : g_below
        always_comb begin
          up_slot[g]   = slot_eff[g+1];
          up_lt_new[g] = flags[g+1].lt_new;
        end
      end

      mmf_cell u_cell (
        .clk       (clk),
        .rst       (rst),
        .ctrl      (ctrl),
        .dn_slot   (dn_slot[g]),
        .up_slot   (up_slot[g]),
        .dn_flags  (dn_flags[g]),
        .up_lt_new (up_lt_new[g]),
        .slot_eff  (slot_eff[g]),
        .flags     (flags[g]),
        .del_here  (del_here[g]),
        .slot_next (slot_next[g])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt      <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (accept) begin
        cnt      <= cnt_next;
        m_tvalid <= (cnt_next == mmf_pkg::CNT_FULL);
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
    if (accept) begin
      m_tdata <= slot_next[mmf_pkg::MID].value;
    end
  end

endmodule

>>> rtl/mmf_checker.sv
module mmf_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [0:0]  s_tuser,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [15:0] m_tdata
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  a_ready: assert property (@(posedge clk) disable iff (rst)
    s_tready == (!m_tvalid || m_tready))
    else $error("input stalled with free output slot");

  a_start: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tuser[0] |=> !m_tvalid)
    else $error("result right after record start");

  a_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(s_tvalid && s_tready))
    else $error("result without an accepted item");

endmodule

bind moving_median_filter mmf_checker u_mmf_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tuser  (s_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

>>> tb/sv/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_ITEMS = 800;
  localparam int CALM_TAIL = 120;

  class median_scoreboard;
    logic signed [mmf_pkg::SAMPLE_W-1:0] window_buf [mmf_pkg::WINDOW];
    int unsigned fill;
    int unsigned oldest;
    logic signed [mmf_pkg::SAMPLE_W-1:0] pending [$];
    int errors;

    function new();
      foreach (window_buf[i]) window_buf[i] = '0;
      fill = 0;
      oldest = 0;
      errors = 0;
    endfunction

    function logic signed [mmf_pkg::SAMPLE_W-1:0] window_median();
      int vals [mmf_pkg::WINDOW];
      int key;
      int j;
      foreach (window_buf[i]) vals[i] = int'(window_buf[i]);
      for (int i = 1; i < mmf_pkg::WINDOW; i++) begin
        key = vals[i];
        j = i - 1;
        while (j >= 0 && vals[j] > key) begin
          vals[j + 1] = vals[j];
          j--;
        end
        vals[j + 1] = key;
      end
      return vals[mmf_pkg::WINDOW / 2][mmf_pkg::SAMPLE_W-1:0];
    endfunction

    function void note_item(logic signed [mmf_pkg::SAMPLE_W-1:0] sample, logic start);
      if (start) begin
        fill = 0;
        oldest = 0;
      end
      window_buf[oldest] = sample;
      oldest = (oldest + 1 >= mmf_pkg::WINDOW) ? 0 : oldest + 1;
      if (fill < mmf_pkg::WINDOW) fill++;
      if (fill == mmf_pkg::WINDOW) pending = {pending, window_median()};
    endfunction

    function void check_result(logic signed [mmf_pkg::SAMPLE_W-1:0] got);
      logic signed [mmf_pkg::SAMPLE_W-1:0] want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected median item, expected none, actual %0d", $time, got);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got !== want) begin
        $display("%0t: median mismatch, expected %0d, actual %0d", $time, want, got);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata = '0;   // [15:0] sample
  logic [0:0]  s_tuser = '0;   // [0] start_req
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;        // [15:0] median

  median_scoreboard board = new();
  int  sent_count = 0;
  bit  calm = 1'b0;
  bit  held = 1'b0;

  moving_median_filter dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #5 clk = ~clk;

  task automatic send_item(input logic [15:0] sample, input logic start);
    int gap;
    if (!calm && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 11);
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= sample;
    s_tuser  <= start;
    do @(posedge clk); while (!s_tready);
    board.note_item(sample, start);
    sent_count++;
    if (sent_count >= NUM_ITEMS - CALM_TAIL) calm = 1'b1;
  endtask

  function automatic logic [15:0] pick_sample(int flavor);
    case (flavor)
      0: return 16'($urandom_range(0, 8) - 4);
      1: begin
        case ($urandom_range(0, 3))
          0: return 16'h7fff;
          1: return 16'h8000;
          2: return 16'h0000;
          default: return 16'hffff;
        endcase
      end
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic random_record();
    int len;
    int flavor;
    logic st;
    if ($urandom_range(0, 5) == 0) len = $urandom_range(1, mmf_pkg::WINDOW - 1);
    else len = $urandom_range(mmf_pkg::WINDOW, mmf_pkg::WINDOW + 50);
    flavor = $urandom_range(0, 5);
    for (int k = 0; k < len; k++) begin
      // first item usually opens a record; sometimes the old one runs on
      st = (k == 0) ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 199) == 0);
      send_item(pick_sample(flavor), st);
    end
  endtask

  // receiver side: random back-pressure plus one long hold-off
  initial begin
    int stall;
    stall = 0;
    forever begin
      @(posedge clk);
      if (m_tvalid && m_tready) board.check_result(m_tdata);
      if (stall > 0) begin
        stall--;
      end else if (!held && sent_count >= 300) begin
        held = 1'b1;
        stall = 150;
      end else if (!calm && !rst && $urandom_range(0, 4) == 0) begin
        stall = $urandom_range(1, 11);
      end
      m_tready <= (stall == 0) && !rst;
    end
  end

  initial begin
    int directed [25];
    directed = '{32767, -32768, 0, -1, 1, 32767, -32768, 16384, -16384, 1,
                 -1, 32767, -32768, 0, 0, -32768, -32768,
                 32767, 32767, -32768, 5, -5, 0, 32767, 1};
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // record from reset without a start flag, then a fresh partial record
    foreach (directed[i]) send_item(16'(directed[i]), i == 17);
    while (sent_count < NUM_ITEMS) random_record();
    s_tvalid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
